@@ hw/rtl/tsot_pkg.sv @@
// tsot_pkg: shared types and constants of the timestamp and one-shot event timer
// holds the function codes, controller states and the controller/datapath
// command and status structs; no dependencies
package tsot_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int TIME_W           = 64;
    localparam int NPT_W            = 10;
    localparam int DIV100_STEPS     = 16;
    localparam int DIV100_CNT_W     = 4;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int REG_IDX_W        = 1;

    localparam logic [NPT_W-1:0]  NPT_RESET      = 10'd200;
    localparam logic [TIME_W-1:0] HNSEC_OVERHEAD = 64'd10;
    localparam logic [TIME_W-1:0] REPORT_EARLY   = 64'd2;

    // register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_NPT = 1'b0;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_ARM_REL = 2'd1,
        FUNC_ARM_ABS = 2'd2,
        FUNC_CANCEL  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_ARM_BASE,
        ST_ARM_OVH,
        ST_ARM_PROD,
        ST_ARM_DIV,
        ST_ARM_SET,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic arm_base;
        logic arm_ovh;
        logic arm_prod;
        logic arm_step;
        logic arm_set;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_arm;
        logic div_last;
        logic arm_last;
    } status_t;

endpackage

@@ hw/rtl/timestamp_and_oneshot_event_timer.sv @@
// a tick or cancel passes the split multiply and the 16-step radix-16 divide by 100;
// an arm then also passes the base, overhead and product steps and the one-bit-per-cycle
// tick divider; one item is in progress at a time, and the input waits until it is done
// a new item is taken while the previous result still waits in the output register
// reset (aresetn low, synchronous): counter, compare, armed flag cleared, resolution 200 ns
module timestamp_and_oneshot_event_timer
    import tsot_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [63:0] time_value
    input  logic [1:0]            s_tuser,   // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,   // [63:0] now_hnsec, [127:64] event_time
    output logic [1:0]            m_tuser,   // [0] event_fired, [1] delay_clamped
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cmd_t              cmd;
    status_t           status;
    logic [NPT_W-1:0]  npt_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic              cfg_wr;
    logic [TIME_W-1:0] now_hnsec;
    logic [TIME_W-1:0] event_time;
    logic              event_fired;
    logic              delay_clamped;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == REG_NPT) ? APB_DATA_W'(npt_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            npt_reg <= NPT_RESET;
        end else if (cfg_wr && reg_idx == REG_NPT) begin
            npt_reg <= pwdata[NPT_W-1:0];
        end
    end

    tsot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tsot_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .npt           (npt_reg),
        .in_func       (func_t'(s_tuser)),
        .in_time       (s_tdata),
        .now_hnsec     (now_hnsec),
        .event_fired   (event_fired),
        .event_time    (event_time),
        .delay_clamped (delay_clamped)
    );

    assign m_tdata = {event_time, now_hnsec};
    assign m_tuser = {delay_clamped, event_fired};

`ifndef ASSERT_OFF
    // one item in flight: an accepted transaction closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // no fire, no timestamp
    a_evt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[127:64] == 64'd0))
        else $error("event_time set without a fired event");

    // reported timestamp never after the current time
    a_evt_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[127:64] <= m_tdata[63:0]))
        else $error("event_time later than now_hnsec");
`endif

endmodule

@@ hw/rtl/tsot_ctrl.sv @@
// tsot_ctrl: sequencing state machine of the event timer
// steps the datapath through time conversion and arming; owns the result valid
// depends on tsot_pkg
module tsot_ctrl
    import tsot_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = status.is_arm ? ST_ARM_BASE : ST_RESULT;
                end
            end
            ST_ARM_BASE: begin
                cmd.arm_base = 1'b1;
                state_next   = ST_ARM_OVH;
            end
            ST_ARM_OVH: begin
                cmd.arm_ovh = 1'b1;
                state_next  = ST_ARM_PROD;
            end
            ST_ARM_PROD: begin
                cmd.arm_prod = 1'b1;
                state_next   = ST_ARM_DIV;
            end
            ST_ARM_DIV: begin
                cmd.arm_step = 1'b1;
                if (status.arm_last) begin
                    state_next = ST_ARM_SET;
                end
            end
            ST_ARM_SET: begin
                cmd.arm_set = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                // wait until the previous result has left the output register
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

@@ hw/rtl/tsot_dp.sv @@
// tsot_dp: datapath of the event timer
// tick counter, split multiplier, radix-16 divide by 100, delay-to-tick divider,
// compare/arm state and the result register; depends on tsot_pkg
module tsot_dp
    import tsot_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [NPT_W-1:0]  npt,
    input  func_t             in_func,
    input  logic [TIME_W-1:0] in_time,
    output logic [TIME_W-1:0] now_hnsec,
    output logic              event_fired,
    output logic [TIME_W-1:0] event_time,
    output logic              delay_clamped
);

    localparam int DIVW   = NPT_W + COUNTER_BITS;
    localparam int ACNT_W = $clog2(COUNTER_BITS);
    localparam int PROD_W = TIME_W + 7;

    // architectural state
    logic [TIME_W-1:0]       tick_count_reg;
    logic [COUNTER_BITS-1:0] compare_value_reg;
    logic                    event_armed_reg;

    // item working registers
    func_t                   func_reg;
    logic [TIME_W-1:0]       tv_reg;
    logic                    fired_reg;
    logic                    clamp_reg;
    logic                    armok_reg;
    logic [TIME_W-1:0]       div_q_reg;
    logic [6:0]              div_rem_reg;
    logic [DIV100_CNT_W-1:0] div_cnt_reg;
    logic [TIME_W-1:0]       d_reg;
    logic [DIVW-1:0]         arem_reg;
    logic [DIVW-2:0]         adv_reg;
    logic [COUNTER_BITS-1:0] aq_reg;
    logic [ACNT_W-1:0]       acnt_reg;

    // result register
    logic [TIME_W-1:0]       now_out_reg;
    logic [TIME_W-1:0]       evt_out_reg;
    logic                    fired_out_reg;
    logic                    clamp_out_reg;

    logic [NPT_W-1:0]        npt_eff;
    logic [TIME_W-1:0]       tick_inc;
    logic [41:0]             lo_prod;
    logic [41:0]             hi_prod;
    logic [10:0]             div_x;
    logic [3:0]              div_digit;
    logic [10:0]             div_sub;
    logic [PROD_W-1:0]       p100;
    logic [TIME_W-1:0]       lim;
    logic                    clamp_now;
    logic                    astep_ge;
    logic [COUNTER_BITS-1:0] ticks;

    assign npt_eff  = (npt == '0) ? NPT_W'(1) : npt;
    assign tick_inc = tick_count_reg + TIME_W'(1);
    assign lo_prod  = tick_count_reg[31:0] * npt_eff;
    assign hi_prod  = tick_count_reg[63:32] * npt_eff;

    // one quotient digit of the divide by 100 per step
    assign div_x = {div_rem_reg, div_q_reg[TIME_W-1 -: 4]};
    always_comb begin
        div_digit = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (div_x >= 11'(k * 100)) begin
                div_digit = 4'(k);
            end
        end
    end
    assign div_sub = div_x - ({7'b0, div_digit} * 11'd100);

    // delay in ns, 7 guard bits catch the overflow of d * 100
    assign p100 = ({7'b0, d_reg} << 6) + ({7'b0, d_reg} << 5) + ({7'b0, d_reg} << 2);
    assign lim  = TIME_W'(npt_eff) << COUNTER_BITS;
    assign clamp_now = (|p100[PROD_W-1:TIME_W]) || (p100[TIME_W-1:0] >= lim);

    assign astep_ge = (arem_reg >= {1'b0, adv_reg});
    assign ticks    = clamp_reg ? '1 : aq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            compare_value_reg <= '0;
            event_armed_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                case (in_func)
                    FUNC_TICK: begin
                        tick_count_reg <= tick_inc;
                        if (event_armed_reg &&
                            tick_inc[COUNTER_BITS-1:0] == compare_value_reg) begin
                            event_armed_reg <= 1'b0;
                        end
                    end
                    FUNC_CANCEL: begin
                        event_armed_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.arm_set) begin
                if (armok_reg) begin
                    compare_value_reg <= tick_count_reg[COUNTER_BITS-1:0] + ticks;
                    event_armed_reg   <= 1'b1;
                end else begin
                    event_armed_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= in_func;
            tv_reg    <= in_time;
            clamp_reg <= 1'b0;
            fired_reg <= (in_func == FUNC_TICK) && event_armed_reg &&
                         (tick_inc[COUNTER_BITS-1:0] == compare_value_reg);
        end
        if (cmd.mul_lo) begin
            div_q_reg <= {22'b0, lo_prod};
        end
        if (cmd.mul_hi) begin
            // product wraps modulo 2^64
            div_q_reg   <= div_q_reg + {hi_prod[31:0], 32'b0};
            div_rem_reg <= '0;
            div_cnt_reg <= DIV100_CNT_W'(DIV100_STEPS - 1);
        end
        if (cmd.div_step) begin
            div_q_reg   <= {div_q_reg[TIME_W-5:0], div_digit};
            div_rem_reg <= div_sub[6:0];
            div_cnt_reg <= div_cnt_reg - DIV100_CNT_W'(1);
        end
        if (cmd.arm_base) begin
            if (func_reg == FUNC_ARM_REL) begin
                d_reg <= tv_reg;
            end else begin
                d_reg <= (tv_reg > div_q_reg) ? tv_reg - div_q_reg : '0;
            end
        end
        if (cmd.arm_ovh) begin
            d_reg <= (d_reg > HNSEC_OVERHEAD) ? d_reg - HNSEC_OVERHEAD : '0;
        end
        if (cmd.arm_prod) begin
            armok_reg <= (d_reg > HNSEC_OVERHEAD);
            clamp_reg <= clamp_now;
            arem_reg  <= p100[DIVW-1:0];
            adv_reg   <= {npt_eff, {(COUNTER_BITS-1){1'b0}}};
            aq_reg    <= '0;
            acnt_reg  <= ACNT_W'(COUNTER_BITS - 1);
        end
        if (cmd.arm_step) begin
            if (astep_ge) begin
                arem_reg <= arem_reg - {1'b0, adv_reg};
            end
            aq_reg   <= {aq_reg[COUNTER_BITS-2:0], astep_ge};
            adv_reg  <= adv_reg >> 1;
            acnt_reg <= acnt_reg - ACNT_W'(1);
        end
        if (cmd.arm_set) begin
            fired_reg <= !armok_reg;
        end
        if (cmd.out_load) begin
            now_out_reg   <= div_q_reg;
            fired_out_reg <= fired_reg;
            clamp_out_reg <= clamp_reg;
            if (fired_reg && div_q_reg > REPORT_EARLY) begin
                evt_out_reg <= div_q_reg - REPORT_EARLY;
            end else begin
                evt_out_reg <= '0;
            end
        end
    end

    assign status.is_arm   = (func_reg == FUNC_ARM_REL) || (func_reg == FUNC_ARM_ABS);
    assign status.div_last = (div_cnt_reg == '0);
    assign status.arm_last = (acnt_reg == '0);

    assign now_hnsec     = now_out_reg;
    assign event_fired   = fired_out_reg;
    assign event_time    = evt_out_reg;
    assign delay_clamped = clamp_out_reg;

endmodule
